/* hw/rtl/quadratic_probe_credential_table_assert.svh */
// Assertion macros for the credential table checker.
// Needs a signal named clock and a signal named reset in the using scope.
`ifndef QUADRATIC_PROBE_CREDENTIAL_TABLE_ASSERT_SVH
`define QUADRATIC_PROBE_CREDENTIAL_TABLE_ASSERT_SVH

// same-cycle implication
`define QPCT_ASSERT_IMPL(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("qpct assertion failed");

// next-cycle implication
`define QPCT_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("qpct assertion failed");

`endif

/* hw/rtl/qpct_pkg.sv */
// Shared types, constants and codes for the credential table.
// No dependencies.
package qpct_pkg;

   localparam int TABLE_SIZE    = 8;
   localparam int KEY_BYTES     = 8;
   localparam int SLOT_W        = $clog2(TABLE_SIZE);
   localparam int PROBE_CNT_W   = $clog2(TABLE_SIZE + 1);
   localparam int BYTE_CNT_W    = $clog2(KEY_BYTES + 1);
   localparam int KEY_W         = 64;
   localparam int DIGEST_W      = 160;
   localparam int USED_W        = 3;
   localparam int ENTRY_COUNT_W = 4;

   localparam logic [KEY_W-1:0] KEY_MASK =
      64'hFFFF_FFFF_FFFF_FFFF >> (8 * (8 - KEY_BYTES));

   typedef logic [SLOT_W-1:0]   slot_type;
   typedef logic [DIGEST_W-1:0] digest_type;

   typedef enum logic [0:0] {
      OP_REGISTER = 1'b0,
      OP_CHECK    = 1'b1
   } opcode_type;

   typedef enum logic [2:0] {
      OUT_INSERTED  = 3'd0,
      OUT_FULL      = 3'd1,
      OUT_MATCH     = 3'd2,
      OUT_DIFFERS   = 3'd3,
      OUT_NOT_FOUND = 3'd4
   } outcome_type;

   typedef struct packed {
      opcode_type  opcode;
      logic [63:0] login_key;
      logic [63:0] digest_high;
      logic [63:0] digest_mid;
      logic [31:0] digest_low;
   } req_type;

   typedef struct packed {
      outcome_type       outcome;
      logic [USED_W-1:0] slot_used;
   } rsp_type;

   typedef struct packed {
      logic             wr_en;
      slot_type         slot;
      logic [KEY_W-1:0] key;
      digest_type       digest;
   } store_cmd_type;

   typedef struct packed {
      logic occupied;
      logic key_match;
      logic digest_match;
   } probe_type;

endpackage

/* hw/rtl/qpct_hash.sv */
// Home slot unit: byte sum mod 10 accumulated one key byte per cycle.
// Depends on qpct_pkg.
module qpct_hash
   import qpct_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [KEY_W-1:0] key,
   output logic             done,
   output slot_type         home
);

   localparam logic [3:0] MUL7_MOD10 [10] = '{
      4'd0, 4'd7, 4'd4, 4'd1, 4'd8, 4'd5, 4'd2, 4'd9, 4'd6, 4'd3
   };

   localparam slot_type HOME_TABLE [10] = '{
      SLOT_W'(TABLE_SIZE * 0 / 10), SLOT_W'(TABLE_SIZE * 1 / 10),
      SLOT_W'(TABLE_SIZE * 2 / 10), SLOT_W'(TABLE_SIZE * 3 / 10),
      SLOT_W'(TABLE_SIZE * 4 / 10), SLOT_W'(TABLE_SIZE * 5 / 10),
      SLOT_W'(TABLE_SIZE * 6 / 10), SLOT_W'(TABLE_SIZE * 7 / 10),
      SLOT_W'(TABLE_SIZE * 8 / 10), SLOT_W'(TABLE_SIZE * 9 / 10)
   };

   localparam logic [16:0] RECIP10 = 17'd205;

   // t < 1029: floor(t/10) = (t*205) >> 11
   function automatic logic [3:0] mod10(input logic [8:0] t);
      logic [16:0] prod;
      logic [8:0]  q;
      logic [8:0]  r;
      prod = {8'd0, t} * RECIP10;
      q    = {3'd0, prod[16:11]};
      r    = t - q * 9'd10;
      return r[3:0];
   endfunction

   logic [KEY_W-1:0]      key_sh_ff;
   logic [BYTE_CNT_W-1:0] left_ff;
   logic [3:0]            acc_ff;
   logic [3:0]            acc_in;
   logic                  busy_ff;
   logic                  done_ff;
   slot_type              home_ff;

   assign acc_in = mod10({5'd0, acc_ff} + {1'b0, key_sh_ff[7:0]});

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
         end else if (busy_ff && left_ff == BYTE_CNT_W'(1)) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end
      if (start) begin
         key_sh_ff <= key;
         left_ff   <= BYTE_CNT_W'(KEY_BYTES);
         acc_ff    <= 4'd0;
      end else if (busy_ff) begin
         key_sh_ff <= key_sh_ff >> 8;
         left_ff   <= left_ff - BYTE_CNT_W'(1);
         acc_ff    <= acc_in;
         home_ff   <= HOME_TABLE[MUL7_MOD10[acc_in]];
      end
   end

   assign done = done_ff;
   assign home = home_ff;

endmodule

/* hw/rtl/qpct_store.sv */
// Slot store: valid bits, keys, digests and the insertion count.
// Depends on qpct_pkg.
module qpct_store
   import qpct_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  store_cmd_type cmd,
   output probe_type     probe
);

   logic [TABLE_SIZE-1:0]    valid_ff;
   logic [KEY_W-1:0]         key_ff [TABLE_SIZE];
   digest_type               digest_ff [TABLE_SIZE];
   logic [ENTRY_COUNT_W-1:0] entry_count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff       <= '0;
         entry_count_ff <= '0;
      end else if (cmd.wr_en) begin
         valid_ff[cmd.slot] <= 1'b1;
         entry_count_ff     <= entry_count_ff + ENTRY_COUNT_W'(1);
      end
      if (cmd.wr_en) begin
         key_ff[cmd.slot]    <= cmd.key;
         digest_ff[cmd.slot] <= cmd.digest;
      end
   end

   always_comb begin
      probe.occupied     = valid_ff[cmd.slot];
      probe.key_match    = key_ff[cmd.slot] == cmd.key;
      probe.digest_match = digest_ff[cmd.slot] == cmd.digest;
   end

endmodule

/* hw/rtl/quadratic_probe_credential_table.sv */
// Credential table top level: request sequencer over qpct_hash and qpct_store.
// Depends on qpct_pkg, qpct_hash, qpct_store.
// A request is one transaction of opcode, login key and 160-bit digest; each
// gives exactly one response transaction. The home slot is computed first
// (one key byte a cycle through the mod-10 accumulator), then the probe loop
// reads one slot a cycle, up to TABLE_SIZE slots, with the insert written in
// the probe cycle that finds a free slot. The finish state then loads the
// response register once the previous response has been taken; req_ready is
// high only between requests. A waiting response holds back the next one but
// not the next request's acceptance.
module quadratic_probe_credential_table
   import qpct_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_HASH,
      ST_PROBE,
      ST_FINISH
   } state_type;

   state_type              state_ff, state_in;
   req_type                req_ff, req_in;
   slot_type               slot_ff, slot_in;
   slot_type               step_ff, step_in;
   logic [PROBE_CNT_W-1:0] cnt_ff, cnt_in;
   outcome_type            outcome_ff, outcome_in;
   logic [USED_W-1:0]      used_ff, used_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   rsp_type                rsp_ff, rsp_in;

   logic                   accept;
   logic                   hash_done;
   slot_type               hash_home;
   store_cmd_type          cmd;
   probe_type              probe;
   logic [SLOT_W:0]        slot_sum;
   logic [SLOT_W:0]        step_sum;
   logic                   miss;

   assign req_ready = state_ff == ST_IDLE;
   assign accept    = req_valid && req_ready;

   qpct_hash u_hash (
      .clock (clock),
      .reset (reset),
      .start (accept),
      .key   (req_data.login_key),
      .done  (hash_done),
      .home  (hash_home)
   );

   qpct_store u_store (
      .clock (clock),
      .reset (reset),
      .cmd   (cmd),
      .probe (probe)
   );

   assign slot_sum = {1'b0, slot_ff} + {1'b0, step_ff};
   assign step_sum = {1'b0, step_ff} + (SLOT_W + 1)'(2);

   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      slot_in      = slot_ff;
      step_in      = step_ff;
      cnt_in       = cnt_ff;
      outcome_in   = outcome_ff;
      used_in      = used_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      miss         = 1'b0;

      cmd.wr_en  = 1'b0;
      cmd.slot   = slot_ff;
      cmd.key    = req_ff.login_key;
      cmd.digest = {req_ff.digest_high, req_ff.digest_mid, req_ff.digest_low};

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               req_in           = req_data;
               req_in.login_key = req_data.login_key & KEY_MASK;
               state_in         = ST_HASH;
            end
         end
         ST_HASH: begin
            if (hash_done) begin
               slot_in  = hash_home;
               step_in  = SLOT_W'(1);
               cnt_in   = '0;
               state_in = ST_PROBE;
            end
         end
         ST_PROBE: begin
            if (req_ff.opcode == OP_REGISTER) begin
               if (!probe.occupied) begin
                  cmd.wr_en  = 1'b1;
                  outcome_in = OUT_INSERTED;
                  used_in    = USED_W'(slot_ff);
                  state_in   = ST_FINISH;
               end else begin
                  miss = 1'b1;
               end
            end else begin
               if (!probe.occupied) begin
                  outcome_in = OUT_NOT_FOUND;
                  used_in    = '0;
                  state_in   = ST_FINISH;
               end else if (probe.key_match) begin
                  outcome_in = probe.digest_match ? OUT_MATCH : OUT_DIFFERS;
                  used_in    = USED_W'(slot_ff);
                  state_in   = ST_FINISH;
               end else begin
                  miss = 1'b1;
               end
            end
            if (miss) begin
               if (cnt_ff == PROBE_CNT_W'(TABLE_SIZE - 1)) begin
                  outcome_in = (req_ff.opcode == OP_REGISTER) ? OUT_FULL : OUT_NOT_FOUND;
                  used_in    = '0;
                  state_in   = ST_FINISH;
               end else begin
                  slot_in = (slot_sum >= (SLOT_W + 1)'(TABLE_SIZE))
                          ? SLOT_W'(slot_sum - (SLOT_W + 1)'(TABLE_SIZE))
                          : SLOT_W'(slot_sum);
                  step_in = (step_sum >= (SLOT_W + 1)'(TABLE_SIZE))
                          ? SLOT_W'(step_sum - (SLOT_W + 1)'(TABLE_SIZE))
                          : SLOT_W'(step_sum);
                  cnt_in  = cnt_ff + PROBE_CNT_W'(1);
               end
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_in.outcome   = outcome_ff;
               rsp_in.slot_used = used_ff;
               rsp_valid_in     = 1'b1;
               state_in         = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      req_ff     <= req_in;
      slot_ff    <= slot_in;
      step_ff    <= step_in;
      cnt_ff     <= cnt_in;
      outcome_ff <= outcome_in;
      used_ff    <= used_in;
      rsp_ff     <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

/* hw/rtl/qpct_checker.sv */
// Port-level checker for the credential table, bound to the top level.
// Depends on qpct_pkg and quadratic_probe_credential_table_assert.svh.
`include "quadratic_probe_credential_table_assert.svh"

module qpct_checker
   import qpct_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_ready,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_data
);

   logic rsp_miss;

   assign rsp_miss = rsp_data.outcome == OUT_FULL || rsp_data.outcome == OUT_NOT_FOUND;

   `QPCT_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data))
   `QPCT_ASSERT_NEXT(a_busy_after_req, req_valid && req_ready, !req_ready)
   `QPCT_ASSERT_NEXT(a_no_instant_rsp, req_valid && req_ready, !$rose(rsp_valid))
   `QPCT_ASSERT_IMPL(a_miss_slot_zero, rsp_valid && rsp_miss, rsp_data.slot_used == '0)
   `QPCT_ASSERT_IMPL(a_outcome_legal, rsp_valid, rsp_data.outcome <= OUT_NOT_FOUND)

endmodule

bind quadratic_probe_credential_table qpct_checker u_qpct_checker (.*);

/* test/tb.sv */
// Testbench for quadratic_probe_credential_table: directed and random register/check
// traffic scored against an in-bench model of the quadratically probed slot table.
// Depends on qpct_pkg and the table RTL.
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import qpct_pkg::*;

   localparam int RANDOM_ITEMS  = 1430;
   localparam int IDLE_LIMIT    = 1000;
   localparam int SETTLE_CYCLES = 40;
   localparam int MAX_GAP       = 18;
   localparam int PRINT_LIMIT   = 100;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   // model of the slot table
   logic                     tbl_valid  [TABLE_SIZE];
   logic [KEY_W-1:0]         tbl_key    [TABLE_SIZE];
   digest_type               tbl_digest [TABLE_SIZE];
   logic [ENTRY_COUNT_W-1:0] insert_total;

   rsp_type pending_rsp[$];
   int      error_count = 0;
   int      idle_cycles = 0;
   int      stall_left  = 0;
   int      req_total   = 0;
   int      seen_outcome[5] = '{default: 0};
   bit      send_burst  = 1'b0;
   bit      recv_burst  = 1'b0;

   quadratic_probe_credential_table u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic int home_of(logic [KEY_W-1:0] key);
      int sum;
      sum = 0;
      for (int b = 0; b < KEY_BYTES; b++) sum += key[8*b +: 8];
      return (TABLE_SIZE * ((7 * sum) % 10)) / 10;
   endfunction

   // Applies one transaction to the model and returns the response it must produce.
   function automatic rsp_type lookup_credential(req_type r);
      logic [KEY_W-1:0] key;
      digest_type       dg;
      int               home;
      int               s;
      rsp_type          res;
      key  = r.login_key & KEY_MASK;
      dg   = {r.digest_high, r.digest_mid, r.digest_low};
      home = home_of(key);
      if (r.opcode == OP_REGISTER) res.outcome = OUT_FULL;
      else res.outcome = OUT_NOT_FOUND;
      res.slot_used = '0;
      for (int i = 0; i < TABLE_SIZE; i++) begin
         s = (home + i * i) % TABLE_SIZE;
         if (r.opcode == OP_REGISTER) begin
            if (!tbl_valid[s]) begin
               tbl_valid[s]  = 1'b1;
               tbl_key[s]    = key;
               tbl_digest[s] = dg;
               insert_total++;
               res.outcome   = OUT_INSERTED;
               res.slot_used = s[USED_W-1:0];
               break;
            end
         end else begin
            if (!tbl_valid[s]) break;
            if (tbl_key[s] == key) begin
               if (tbl_digest[s] == dg) res.outcome = OUT_MATCH;
               else res.outcome = OUT_DIFFERS;
               res.slot_used = s[USED_W-1:0];
               break;
            end
         end
      end
      return res;
   endfunction

   function automatic logic [KEY_W-1:0] key_for_home(int h);
      logic [KEY_W-1:0] k;
      do k = {$urandom, $urandom}; while (home_of(k & KEY_MASK) != h);
      return k;
   endfunction

   function automatic digest_type random_digest();
      return {$urandom, $urandom, $urandom, $urandom, $urandom};
   endfunction

   function automatic req_type make_req(opcode_type op, logic [KEY_W-1:0] key, digest_type dg);
      req_type r;
      r.opcode    = op;
      r.login_key = key;
      {r.digest_high, r.digest_mid, r.digest_low} = dg;
      return r;
   endfunction

   task automatic report_mismatch(input string msg);
      error_count++;
      if (error_count <= PRINT_LIMIT) $display("MISMATCH @%0t: %s", $time, msg);
   endtask

   task automatic send_request(input req_type r);
      int gap;
      gap = send_burst ? 0 : $urandom_range(0, MAX_GAP);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      do @(posedge clock); while (!req_ready);
      req_total++;
      pending_rsp.push_back(lookup_credential(r));
   endtask

   // drops req_valid so the last transaction is not offered again
   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_rsp.size() != 0);
   endtask

   // response side: random stalls and scoring
   always @(posedge clock) begin
      rsp_type want;
      int      n;
      if (reset) begin
         rsp_ready  <= 1'b0;
         stall_left <= 0;
      end else if (rsp_valid && rsp_ready) begin
         if (pending_rsp.size() == 0) begin
            report_mismatch($sformatf("unexpected transaction: outcome %0d slot %0d",
                                      rsp_data.outcome, rsp_data.slot_used));
         end else begin
            want = pending_rsp.pop_front();
            if (rsp_data.outcome !== want.outcome)
               report_mismatch($sformatf("outcome %0d, want %0d",
                                         rsp_data.outcome, want.outcome));
            if (rsp_data.slot_used !== want.slot_used)
               report_mismatch($sformatf("slot_used %0d, want %0d",
                                         rsp_data.slot_used, want.slot_used));
            seen_outcome[int'(want.outcome)]++;
         end
         n = recv_burst ? 0 : $urandom_range(0, MAX_GAP);
         stall_left <= n;
         rsp_ready  <= (n == 0);
      end else if (stall_left != 0) begin
         stall_left <= stall_left - 1;
         rsp_ready  <= (stall_left == 1);
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles <= 0;
         else idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("Timeout: no transaction for %0d cycles", IDLE_LIMIT);
            $display("RESULT: ERROR");
            $finish;
         end
      end
   end

   task automatic test_empty_table();
      send_request(make_req(OP_CHECK, '0, '0));
      send_request(make_req(OP_CHECK, '1, '1));
   endtask

   // Home slot 0 reaches only slots 0, 1 and 4; the fourth insert is refused
   // while other slots are still free. Duplicate key resolves to first slot.
   task automatic test_home_collisions();
      digest_type dr;
      dr = random_digest();
      send_request(make_req(OP_REGISTER, '0, '0));
      send_request(make_req(OP_REGISTER, '1, '1));
      send_request(make_req(OP_REGISTER, '0, dr));
      send_request(make_req(OP_REGISTER, key_for_home(0), random_digest()));
      send_request(make_req(OP_CHECK, '0, '0));
      send_request(make_req(OP_CHECK, '0, dr));
      send_request(make_req(OP_CHECK, '1, '1));
      send_request(make_req(OP_CHECK, '1, '1 ^ (digest_type'(1) << (DIGEST_W - 1))));
   endtask

   task automatic test_free_slot_miss();
      logic [KEY_W-1:0] ka;
      logic [KEY_W-1:0] kb;
      digest_type       da;
      digest_type       db;
      ka = key_for_home(7);
      kb = key_for_home(7);
      da = random_digest();
      db = random_digest();
      send_request(make_req(OP_CHECK, key_for_home(2), random_digest()));
      send_request(make_req(OP_REGISTER, ka, da));
      send_request(make_req(OP_REGISTER, kb, db));
      send_request(make_req(OP_CHECK, kb, db));
      send_request(make_req(OP_CHECK, ka, da ^ digest_type'(1)));
   endtask

   task automatic test_fill_table();
      logic [KEY_W-1:0] k6;
      digest_type       d6;
      k6 = key_for_home(6);
      d6 = random_digest();
      send_request(make_req(OP_REGISTER, key_for_home(2), random_digest()));
      send_request(make_req(OP_REGISTER, key_for_home(3), random_digest()));
      send_request(make_req(OP_REGISTER, k6, d6));
      wait_drained();
      send_request(make_req(OP_CHECK, {$urandom, $urandom}, random_digest()));
      send_request(make_req(OP_REGISTER, {$urandom, $urandom}, random_digest()));
      send_request(make_req(OP_CHECK, k6, d6));
   endtask

   task automatic test_random_traffic(input int n);
      int               pick;
      int               s;
      opcode_type       op;
      logic [KEY_W-1:0] k;
      digest_type       dg;
      for (int i = 0; i < n; i++) begin
         if (i % 64 == 0) begin
            send_burst = ($urandom_range(0, 3) == 0);
            recv_burst <= ($urandom_range(0, 3) == 0);
         end
         if (i == n / 2) wait_drained();
         pick = $urandom_range(0, 99);
         s    = $urandom_range(0, TABLE_SIZE - 1);
         op   = OP_CHECK;
         k    = {$urandom, $urandom};
         dg   = random_digest();
         if (tbl_valid[s] && pick < 45) begin
            k  = tbl_key[s];
            dg = tbl_digest[s];
         end else if (tbl_valid[s] && pick < 65) begin
            k = tbl_key[s];
            if (pick[0]) dg = tbl_digest[s] ^ (digest_type'(1) << $urandom_range(0, DIGEST_W - 1));
         end else if (pick >= 75) begin
            op = OP_REGISTER;
            if (tbl_valid[s] && pick >= 88) k = tbl_key[s];
         end
         send_request(make_req(op, k, dg));
      end
   endtask

   initial begin
      foreach (tbl_valid[s]) begin
         tbl_valid[s]  = 1'b0;
         tbl_key[s]    = '0;
         tbl_digest[s] = '0;
      end
      insert_total = '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      test_empty_table();
      test_home_collisions();
      test_free_slot_miss();
      test_fill_table();
      test_random_traffic(RANDOM_ITEMS);
      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      $display("Sent %0d requests: %0d inserted, %0d full, %0d match, %0d differ, %0d absent",
               req_total, seen_outcome[0], seen_outcome[1], seen_outcome[2],
               seen_outcome[3], seen_outcome[4]);
      $display("Insert counter ends at %0d; %0d mismatches", insert_total, error_count);
      if (error_count == 0 && pending_rsp.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

/* files.f */
+incdir+hw/rtl
hw/rtl/qpct_pkg.sv
hw/rtl/qpct_hash.sv
hw/rtl/qpct_store.sv
hw/rtl/quadratic_probe_credential_table.sv
hw/rtl/qpct_checker.sv
test/tb.sv
